@@ hdl/escu_pkg.sv @@
// Shared types, constants and the divider step function for the compensation unit.
`timescale 1ns / 1ps

package escu_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFFS       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_COEFFS_LOW  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_COEFFS_HIGH = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_COEFF_NINE  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_COEFFS_LOW    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_COEFFS_HIGH   = 8'd5;

    // Humidity upper clamp in Q10.22.
    localparam logic [31:0] HUM_MAX = 32'd419430400;

    // Pipelined divider geometry: 64-bit dividend magnitude, 31-bit divisor magnitude.
    localparam int NUM_W         = 64;
    localparam int DEN_W         = 31;
    localparam int REM_W         = DEN_W + 1;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_STAGES    = NUM_W / DIV_STEP_BITS;

    // Results that ride alongside the division.
    typedef struct packed {
        logic [23:0] tc;
        logic        trange;
        logic [16:0] hum;
        logic        pinv;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] num;
    } t_div_state;

    // Restoring division: shifts quotient bits into the low end of num.
    function automatic t_div_state div_step(t_div_state s, logic [DEN_W-1:0] den);
        t_div_state       r;
        logic [REM_W-1:0] t;
        r = s;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            t     = {r.rem[REM_W-2:0], r.num[NUM_W-1]};
            r.num = {r.num[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                r.rem    = t - {1'b0, den};
                r.num[0] = 1'b1;
            end else begin
                r.rem = t;
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/escu_if.sv @@
// Stream interfaces for raw samples and compensated results.
`timescale 1ns / 1ps

interface escu_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;

    modport source (output valid, output raw_temp, output raw_press, output raw_hum,
                    input ready);
    modport sink   (input valid, input raw_temp, input raw_press, input raw_hum,
                    output ready);
endinterface

interface escu_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] temp_centi;
    logic [31:0] press_pa_q8;
    logic [16:0] hum_q10;
    logic        press_invalid;
    logic        temp_out_of_range;

    modport source (output valid, output temp_centi, output press_pa_q8, output hum_q10,
                    output press_invalid, output temp_out_of_range, input ready);
    modport sink   (input valid, input temp_centi, input press_pa_q8, input hum_q10,
                    input press_invalid, input temp_out_of_range, output ready);
endinterface

@@ hdl/escu_div.sv @@
// Pipelined unsigned-magnitude divider with sign fix-up and side-band results.
`timescale 1ns / 1ps

module escu_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [escu_pkg::NUM_W-1:0] i_num,
    input  logic [escu_pkg::DEN_W-1:0] i_den,
    input  logic                       i_neg,
    input  escu_pkg::t_side            i_side,
    output logic                       o_valid,
    output logic [escu_pkg::NUM_W-1:0] o_quot,
    output escu_pkg::t_side            o_side
);

    localparam int LAST = escu_pkg::DIV_STAGES - 1;

    escu_pkg::t_div_state       r_st   [escu_pkg::DIV_STAGES];
    escu_pkg::t_div_state       n_st   [escu_pkg::DIV_STAGES];
    logic [escu_pkg::DEN_W-1:0] r_den  [escu_pkg::DIV_STAGES];
    logic                       r_neg  [escu_pkg::DIV_STAGES];
    escu_pkg::t_side            r_side [escu_pkg::DIV_STAGES];
    logic [escu_pkg::DIV_STAGES-1:0] r_vld;
    logic                       r_ov;
    logic [escu_pkg::NUM_W-1:0] r_quot;
    escu_pkg::t_side            r_oside;

    always_comb begin
        n_st[0] = escu_pkg::div_step('{rem: '0, num: i_num}, i_den);
        for (int k = 1; k < escu_pkg::DIV_STAGES; k++) begin
            n_st[k] = escu_pkg::div_step(r_st[k-1], r_den[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (i_en) begin
            r_vld <= {r_vld[escu_pkg::DIV_STAGES-2:0], i_valid};
            r_ov  <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_neg[0]  <= i_neg;
            r_side[0] <= i_side;
            for (int k = 0; k < escu_pkg::DIV_STAGES; k++) begin
                r_st[k] <= n_st[k];
            end
            for (int k = 1; k < escu_pkg::DIV_STAGES; k++) begin
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
            r_quot  <= r_neg[LAST] ? ({escu_pkg::NUM_W{1'b0}} - r_st[LAST].num)
                                   : r_st[LAST].num;
            r_oside <= r_side[LAST];
        end
    end

    assign o_valid = r_ov;
    assign o_quot  = r_quot;
    assign o_side  = r_oside;

endmodule

@@ hdl/env_sensor_compensation_unit.sv @@
// Top level of the temperature, pressure and humidity compensation pipeline.
//
//   Channel    Dir  Handshake      Contents
//   i_sample   in   valid/ready    raw_temp[19:0], raw_press[19:0], raw_hum[15:0]
//   o_result   out  valid/ready    temp_centi, press_pa_q8, hum_q10, flags
//   i_cfg_*    in   write enable   register index, 64-bit data, no read-back
//
// One sample is taken per cycle unless the output stalls. Results pass 11 front
// stages, 33 divider stages (two quotient bits in each but the last, which fixes
// the sign) and 6 back stages. The whole pipeline advances together whenever
// the output register is empty or its result is being taken, so a stall freezes
// every stage in place. Reset is synchronous and clears valid and coefficient registers.
`timescale 1ns / 1ps

module env_sensor_compensation_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [escu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [escu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    escu_in_if.sink                        i_sample,
    escu_out_if.source                     o_result
);

    // ------------------------------------------------------------------
    // Calibration registers. They must be written only while the pipeline is empty,
    // so every stage reads the coefficients directly; the block does not enforce this.
    // ------------------------------------------------------------------
    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [15:0] r_press_nine;
    logic [31:0] r_hum_lo;
    logic [31:0] r_hum_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_lo    <= '0;
            r_press_hi    <= '0;
            r_press_nine  <= '0;
            r_hum_lo      <= '0;
            r_hum_hi      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                escu_pkg::CFG_TEMP_COEFFS:       r_temp_coeffs <= i_cfg_data[47:0];
                escu_pkg::CFG_PRESS_COEFFS_LOW:  r_press_lo    <= i_cfg_data;
                escu_pkg::CFG_PRESS_COEFFS_HIGH: r_press_hi    <= i_cfg_data;
                escu_pkg::CFG_PRESS_COEFF_NINE:  r_press_nine  <= i_cfg_data[15:0];
                escu_pkg::CFG_HUM_COEFFS_LOW:    r_hum_lo      <= i_cfg_data[31:0];
                escu_pkg::CFG_HUM_COEFFS_HIGH:   r_hum_hi      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic        [15:0] coef_t1, coef_p1;
    logic signed [15:0] coef_t2, coef_t3;
    logic signed [15:0] coef_p2, coef_p3, coef_p4, coef_p5, coef_p6, coef_p7, coef_p8;
    logic signed [15:0] coef_p9, coef_h2;
    logic        [7:0]  coef_h1, coef_h3;
    logic signed [11:0] coef_h4, coef_h5;
    logic signed [7:0]  coef_h6;

    assign coef_t1 = r_temp_coeffs[15:0];
    assign coef_t2 = r_temp_coeffs[31:16];
    assign coef_t3 = r_temp_coeffs[47:32];
    assign coef_p1 = r_press_lo[15:0];
    assign coef_p2 = r_press_lo[31:16];
    assign coef_p3 = r_press_lo[47:32];
    assign coef_p4 = r_press_lo[63:48];
    assign coef_p5 = r_press_hi[15:0];
    assign coef_p6 = r_press_hi[31:16];
    assign coef_p7 = r_press_hi[47:32];
    assign coef_p8 = r_press_hi[63:48];
    assign coef_p9 = r_press_nine;
    assign coef_h1 = r_hum_lo[7:0];
    assign coef_h2 = r_hum_lo[23:8];
    assign coef_h3 = r_hum_lo[31:24];
    assign coef_h4 = r_hum_hi[11:0];
    assign coef_h5 = r_hum_hi[23:12];
    assign coef_h6 = r_hum_hi[31:24];

    // ------------------------------------------------------------------
    // Global advance. Every stage moves when the output slot is free or its result is taken.
    // ------------------------------------------------------------------
    logic r_ov;
    logic n_en;

    assign n_en           = !r_ov || o_result.ready;
    assign i_sample.ready = n_en;

    logic [10:0] r_fv;
    logic [4:0]  r_pv;
    logic        div_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_pv <= '0;
            r_ov <= 1'b0;
        end else if (n_en) begin
            r_fv <= {r_fv[9:0], i_sample.valid};
            r_pv <= {r_pv[3:0], div_valid};
            r_ov <= r_pv[4];
        end
    end

    // ------------------------------------------------------------------
    // Front stages: fine temperature, then the pressure terms and the
    // humidity chain in parallel. The temperature products never wrap, and
    // with the fine temperature held to 25 bits neither do the pressure
    // terms up to the divisor scaling, so those are computed exactly.
    // ------------------------------------------------------------------
    // Stage 1: offsets from T1 and the first products.
    logic signed [18:0] n_d1;
    logic signed [17:0] n_d2;
    logic signed [34:0] r1_m1;
    logic signed [35:0] r1_m2;
    logic [19:0] r1_rp;
    logic [15:0] r1_rh;

    assign n_d1 = $signed({2'b0, i_sample.raw_temp[19:3]}) - $signed({2'b0, coef_t1, 1'b0});
    assign n_d2 = $signed({2'b0, i_sample.raw_temp[19:4]}) - $signed({2'b0, coef_t1});

    // Stage 2.
    logic signed [23:0] n_q;
    logic signed [23:0] r2_a1;
    logic signed [39:0] r2_m3;
    logic [19:0] r2_rp;
    logic [15:0] r2_rh;

    assign n_q = r1_m2[35:12];

    // Stage 3: fine temperature.
    logic signed [25:0] n_fine;
    logic signed [24:0] r3_fine;
    logic [19:0] r3_rp;
    logic [15:0] r3_rh;

    assign n_fine = 26'(r2_a1) + $signed(r2_m3[39:14]);

    // Stage 4: centidegrees, pressure and humidity offsets with their products.
    // The saturation to 24 bits cannot trigger for a 25-bit fine temperature.
    logic signed [27:0] n_tc5;
    logic signed [19:0] n_tc;
    logic signed [24:0] n_v1, n_hv;
    logic signed [36:0] n_hm5;
    logic signed [32:0] n_hm6;
    logic signed [33:0] n_hm3;
    logic signed [49:0] r4_vv;
    logic signed [40:0] r4_v1p5, r4_v1p2;
    logic [31:0] r4_hm5, r4_hm6, r4_hm3;
    logic [23:0] r4_tc;
    logic        r4_trange;
    logic [19:0] r4_rp;
    logic [15:0] r4_rh;

    assign n_tc5 = 28'(r3_fine) * 28'sd5 + 28'sd128;
    assign n_tc  = n_tc5[27:8];
    assign n_v1  = r3_fine - 25'sd128000;
    assign n_hv  = r3_fine - 25'sd76800;
    assign n_hm5 = coef_h5 * n_hv;
    assign n_hm6 = n_hv * coef_h6;
    assign n_hm3 = n_hv * $signed({1'b0, coef_h3});

    // Stage 5.
    logic signed [65:0] n_x1, n_x2;
    logic [31:0] n_hx_sum;
    logic signed [62:0] r5_x1, r5_x2;
    logic signed [40:0] r5_v1p5, r5_v1p2;
    logic [31:0] r5_hx, r5_i1, r5_i2;
    logic [23:0] r5_tc;
    logic        r5_trange;
    logic [19:0] r5_rp;

    assign n_x1     = r4_vv * coef_p6;
    assign n_x2     = r4_vv * coef_p3;
    assign n_hx_sum = {2'b0, r4_rh, 14'b0} - {coef_h4, 20'b0} - r4_hm5 + 32'd16384;

    // Stage 6: v2, and the divisor before its scaling by P1.
    logic signed [63:0] n_v2, n_w1;
    logic signed [63:0] r6_v2, r6_s;
    logic [31:0] r6_hm, r6_hx;
    logic [23:0] r6_tc;
    logic        r6_trange;
    logic [19:0] r6_rp;

    assign n_v2 = 64'(r5_x1) + (64'(r5_v1p5) <<< 17) + (64'(coef_p4) <<< 35);
    assign n_w1 = (64'(r5_x2) >>> 8) + (64'(r5_v1p2) <<< 12);

    // Stage 7: split products for the P1 scaling; dividend before scaling.
    logic [20:0] n_pr;
    logic [31:0] n_tt;
    logic [47:0] r7_sl;
    logic [31:0] r7_sh;
    logic [63:0] r7_n0;
    logic [31:0] r7_hm2, r7_hx;
    logic [23:0] r7_tc;
    logic        r7_trange;

    assign n_pr = 21'd1048576 - {1'b0, r6_rp};
    assign n_tt = ($signed(r6_hm) >>> 10) + 32'sd2097152;

    // Stage 8: divisor; split products for the dividend scaling by 3125.
    logic [63:0] n_prod;
    logic [31:0] n_tt2;
    logic signed [30:0] r8_den;
    logic [43:0] r8_nl;
    logic [31:0] r8_nh;
    logic [31:0] r8_hval;
    logic [23:0] r8_tc;
    logic        r8_trange;

    assign n_prod = {16'b0, r7_sl} + {r7_sh, 32'b0};
    assign n_tt2  = $signed(r7_hm2 + 32'd8192) >>> 14;

    // Stage 9: dividend.
    logic [31:0] n_hs;
    logic [63:0] r9_num;
    logic signed [30:0] r9_den;
    logic [31:0] r9_hss, r9_hval;
    logic [23:0] r9_tc;
    logic        r9_trange;

    assign n_hs = $signed(r8_hval) >>> 15;

    // Stage 10: magnitudes and quotient sign. A zero divisor becomes one so the
    // divider stays well defined; the result is forced to zero at the end.
    logic [31:0] n_h7;
    logic [63:0] r10_nmag;
    logic [30:0] r10_dmag;
    logic        r10_neg, r10_pinv;
    logic [31:0] r10_hc, r10_hval;
    logic [23:0] r10_tc;
    logic        r10_trange;

    assign n_h7 = $signed(r9_hss) >>> 7;

    // Stage 11: humidity correction and clamp.
    logic [31:0] n_corr, n_hf, n_hcl;
    logic [63:0] r11_nmag;
    logic [30:0] r11_dmag;
    logic        r11_neg;
    escu_pkg::t_side r11_side;

    assign n_corr = $signed(r10_hc) >>> 4;
    assign n_hf   = r10_hval - n_corr;

    always_comb begin
        if (n_hf[31]) begin
            n_hcl = '0;
        end else if (n_hf > escu_pkg::HUM_MAX) begin
            n_hcl = escu_pkg::HUM_MAX;
        end else begin
            n_hcl = n_hf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            // Stage 1
            r1_m1 <= n_d1 * coef_t2;
            r1_m2 <= n_d2 * n_d2;
            r1_rp <= i_sample.raw_press;
            r1_rh <= i_sample.raw_hum;
            // Stage 2
            r2_a1 <= r1_m1[34:11];
            r2_m3 <= n_q * coef_t3;
            r2_rp <= r1_rp;
            r2_rh <= r1_rh;
            // Stage 3
            r3_fine <= n_fine[24:0];
            r3_rp   <= r2_rp;
            r3_rh   <= r2_rh;
            // Stage 4
            r4_tc     <= 24'(n_tc);
            r4_trange <= (n_tc < -20'sd4000) || (n_tc > 20'sd8500);
            r4_vv     <= n_v1 * n_v1;
            r4_v1p5   <= n_v1 * coef_p5;
            r4_v1p2   <= n_v1 * coef_p2;
            r4_hm5    <= n_hm5[31:0];
            r4_hm6    <= n_hm6[31:0];
            r4_hm3    <= n_hm3[31:0];
            r4_rp     <= r3_rp;
            r4_rh     <= r3_rh;
            // Stage 5
            r5_x1     <= n_x1[62:0];
            r5_x2     <= n_x2[62:0];
            r5_v1p5   <= r4_v1p5;
            r5_v1p2   <= r4_v1p2;
            r5_hx     <= $signed(n_hx_sum) >>> 15;
            r5_i1     <= $signed(r4_hm6) >>> 10;
            r5_i2     <= ($signed(r4_hm3) >>> 11) + 32'sd32768;
            r5_tc     <= r4_tc;
            r5_trange <= r4_trange;
            r5_rp     <= r4_rp;
            // Stage 6
            r6_v2     <= n_v2;
            r6_s      <= n_w1 + 64'sd140737488355328;
            r6_hm     <= r5_i1 * r5_i2;
            r6_hx     <= r5_hx;
            r6_tc     <= r5_tc;
            r6_trange <= r5_trange;
            r6_rp     <= r5_rp;
            // Stage 7
            r7_sl     <= r6_s[31:0] * coef_p1;
            r7_sh     <= r6_s[63:32] * {16'b0, coef_p1};
            r7_n0     <= {12'b0, n_pr, 31'b0} - r6_v2;
            r7_hm2    <= n_tt * {{16{coef_h2[15]}}, coef_h2};
            r7_hx     <= r6_hx;
            r7_tc     <= r6_tc;
            r7_trange <= r6_trange;
            // Stage 8
            r8_den    <= n_prod[63:33];
            r8_nl     <= r7_n0[31:0] * 12'd3125;
            r8_nh     <= r7_n0[63:32] * 32'd3125;
            r8_hval   <= r7_hx * n_tt2;
            r8_tc     <= r7_tc;
            r8_trange <= r7_trange;
            // Stage 9
            r9_num    <= {20'b0, r8_nl} + {r8_nh, 32'b0};
            r9_den    <= r8_den;
            r9_hss    <= n_hs * n_hs;
            r9_hval   <= r8_hval;
            r9_tc     <= r8_tc;
            r9_trange <= r8_trange;
            // Stage 10
            r10_nmag   <= r9_num[63] ? (64'd0 - r9_num) : r9_num;
            if (r9_den == 31'sd0) begin
                r10_dmag <= 31'd1;
            end else begin
                r10_dmag <= r9_den[30] ? (31'd0 - r9_den) : r9_den;
            end
            r10_neg    <= r9_num[63] ^ r9_den[30];
            r10_pinv   <= (r9_den == 31'sd0);
            r10_hc     <= n_h7 * {24'b0, coef_h1};
            r10_hval   <= r9_hval;
            r10_tc     <= r9_tc;
            r10_trange <= r9_trange;
            // Stage 11
            r11_nmag        <= r10_nmag;
            r11_dmag        <= r10_dmag;
            r11_neg         <= r10_neg;
            r11_side.tc     <= r10_tc;
            r11_side.trange <= r10_trange;
            r11_side.hum    <= n_hcl[28:12];
            r11_side.pinv   <= r10_pinv;
        end
    end

    // ------------------------------------------------------------------
    // Division, truncating toward zero on the signed operands.
    // ------------------------------------------------------------------
    logic [63:0]     div_quot;
    escu_pkg::t_side div_side;

    escu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (r_fv[10]),
        .i_num   (r11_nmag),
        .i_den   (r11_dmag),
        .i_neg   (r11_neg),
        .i_side  (r11_side),
        .o_valid (div_valid),
        .o_quot  (div_quot),
        .o_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Back stages: the two correction terms on the quotient. Products that
    // can exceed 64 bits are split at bit 32 and recombined one stage later.
    // ------------------------------------------------------------------
    logic signed [63:0] n_ps;
    logic [63:0] r_q1_ll, r_q1_q;
    logic [31:0] r_q1_pc, r_q1_eh;
    logic signed [48:0] r_q1_el;
    escu_pkg::t_side r_q1_side;

    assign n_ps = $signed(div_quot) >>> 13;

    logic [63:0] r_q2_pp, r_q2_e2, r_q2_q;
    escu_pkg::t_side r_q2_side;

    logic signed [48:0] r_q3_fl;
    logic [31:0] r_q3_fh;
    logic [63:0] r_q3_e2, r_q3_q;
    escu_pkg::t_side r_q3_side;

    logic [63:0] r_q4_e1, r_q4_e2, r_q4_q;
    escu_pkg::t_side r_q4_side;

    logic [63:0] r_q5_sum;
    escu_pkg::t_side r_q5_side;

    logic [31:0] n_press;
    logic [23:0] r_out_tc;
    logic [31:0] r_out_press;
    logic [16:0] r_out_hum;
    logic        r_out_pinv, r_out_trange;

    assign n_press = r_q5_sum[39:8] + {{12{coef_p7[15]}}, coef_p7, 4'b0};

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            // Square of the scaled quotient and the P8 term, split.
            r_q1_ll   <= n_ps[31:0] * n_ps[31:0];
            r_q1_pc   <= n_ps[63:32] * n_ps[31:0];
            r_q1_el   <= $signed({1'b0, div_quot[31:0]}) * coef_p8;
            r_q1_eh   <= div_quot[63:32] * {{16{coef_p8[15]}}, coef_p8};
            r_q1_q    <= div_quot;
            r_q1_side <= div_side;
            // Recombine.
            r_q2_pp   <= r_q1_ll + {r_q1_pc[30:0], 1'b0, 32'b0};
            r_q2_e2   <= $signed(64'(r_q1_el) + {r_q1_eh, 32'b0}) >>> 19;
            r_q2_q    <= r_q1_q;
            r_q2_side <= r_q1_side;
            // P9 term, split.
            r_q3_fl   <= $signed({1'b0, r_q2_pp[31:0]}) * coef_p9;
            r_q3_fh   <= r_q2_pp[63:32] * {{16{coef_p9[15]}}, coef_p9};
            r_q3_e2   <= r_q2_e2;
            r_q3_q    <= r_q2_q;
            r_q3_side <= r_q2_side;
            // Recombine.
            r_q4_e1   <= $signed(64'(r_q3_fl) + {r_q3_fh, 32'b0}) >>> 25;
            r_q4_e2   <= r_q3_e2;
            r_q4_q    <= r_q3_q;
            r_q4_side <= r_q3_side;
            // Sum of the quotient and both corrections.
            r_q5_sum  <= r_q4_q + r_q4_e1 + r_q4_e2;
            r_q5_side <= r_q4_side;
            // Output register: only the low 32 bits of the final pressure leave.
            r_out_press  <= r_q5_side.pinv ? 32'd0 : n_press;
            r_out_tc     <= r_q5_side.tc;
            r_out_hum    <= r_q5_side.hum;
            r_out_pinv   <= r_q5_side.pinv;
            r_out_trange <= r_q5_side.trange;
        end
    end

    assign o_result.valid             = r_ov;
    assign o_result.temp_centi        = r_out_tc;
    assign o_result.press_pa_q8       = r_out_press;
    assign o_result.hum_q10           = r_out_hum;
    assign o_result.press_invalid     = r_out_pinv;
    assign o_result.temp_out_of_range = r_out_trange;

    // ------------------------------------------------------------------
    // Checks on the delivered result.
    // ------------------------------------------------------------------
    a_pinv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.press_invalid) |-> (o_result.press_pa_q8 == 32'd0))
        else $error("invalid pressure result is not zero");

    a_hum_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.hum_q10 <= 17'd102400))
        else $error("humidity result above clamp");

    a_trange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.temp_out_of_range ==
            (($signed(o_result.temp_centi) < -24'sd4000) ||
             ($signed(o_result.temp_centi) > 24'sd8500))))
        else $error("temperature range flag disagrees with temperature");

endmodule

@@ dv/env_sensor_compensation_unit_tb.sv @@
// Self-checking testbench for the sensor compensation pipeline.
`timescale 1ns / 1ps

module env_sensor_compensation_unit_tb;

    // One compensated reading, laid out in the order of the result channel.
    typedef struct packed {
        logic [23:0] temp_centi;
        logic [31:0] press_pa_q8;
        logic [16:0] hum_q10;
        logic        press_invalid;
        logic        temp_out_of_range;
    } t_reading;

    // A directed row: raw sample plus the reading seen with reset coefficients.
    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
        t_reading    at_reset;
    } t_sample_row;

    // With every coefficient at zero the fine temperature is zero, the pressure
    // divisor is zero and the humidity product collapses, so every sample reads
    // as zero with the pressure flagged invalid.
    localparam t_reading ZERO_CAL_READING = '{24'd0, 32'd0, 17'd0, 1'b1, 1'b0};
    localparam int NUM_ROWS = 12;
    localparam int LATENCY  = 50;

    localparam logic [escu_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd9;

    // Datasheet-style calibration, packed into the register layouts.
    localparam logic [63:0] CAL_TEMP   = {16'h0000, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] CAL_P_LOW  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] CAL_P_HIGH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [63:0] CAL_P_NINE = 64'd6000;
    localparam logic [63:0] CAL_H_LOW  = {32'd0, 8'd0, 16'd362, 8'd75};
    localparam logic [63:0] CAL_H_HIGH = {32'd0, 8'd30, 12'd50, 12'd313};

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [escu_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [63:0]                    cfg_data;

    escu_in_if  sample_if ();
    escu_out_if result_if ();

    env_sensor_compensation_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (sample_if),
        .o_result   (result_if)
    );

    // Local copy of the calibration registers, masked to their widths.
    logic [47:0] temp_cal;
    logic [63:0] press_cal_lo;
    logic [63:0] press_cal_hi;
    logic [15:0] press_cal_nine;
    logic [31:0] hum_cal_lo;
    logic [31:0] hum_cal_hi;

    t_reading    pending_readings[$];
    logic        row_is_typed[$];
    t_reading    row_typed_value[$];
    int          mismatches;
    int          samples_taken;
    bit          steady_flow;
    t_sample_row sample_rows[NUM_ROWS];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Integer compensation of one raw sample under the current calibration.
    function automatic t_reading compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
        t_reading r;
        longint   t1, t2, t3, d1, d2, fine, tc;
        longint   p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint   v1, v2, w1, pp, num, ps, e1, e2, rtl, rpl;
        int       h1, h2, h3, h4, h5, h6, hv, x, i1, i2, tt, hval, hs, corr;
        logic [31:0] hum_shifted;
        rtl = longint'({44'd0, rt});
        rpl = longint'({44'd0, rp});
        t1  = longint'({48'd0, temp_cal[15:0]});
        t2  = longint'($signed(temp_cal[31:16]));
        t3  = longint'($signed(temp_cal[47:32]));
        d1  = (rtl >>> 3) - (t1 <<< 1);
        d2  = (rtl >>> 4) - t1;
        fine = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
        tc  = (fine * 5 + 128) >>> 8;
        if (tc < -8388608) begin
            tc = -8388608;
        end else if (tc > 8388607) begin
            tc = 8388607;
        end
        r.temp_centi        = tc[23:0];
        r.temp_out_of_range = (tc < -4000) || (tc > 8500);

        // Pressure wraps modulo 2^64 at every step, as a 64-bit datapath does.
        p1 = longint'({48'd0, press_cal_lo[15:0]});
        p2 = longint'($signed(press_cal_lo[31:16]));
        p3 = longint'($signed(press_cal_lo[47:32]));
        p4 = longint'($signed(press_cal_lo[63:48]));
        p5 = longint'($signed(press_cal_hi[15:0]));
        p6 = longint'($signed(press_cal_hi[31:16]));
        p7 = longint'($signed(press_cal_hi[47:32]));
        p8 = longint'($signed(press_cal_hi[63:48]));
        p9 = longint'($signed(press_cal_nine));
        v1 = fine - 128000;
        v2 = v1 * v1 * p6 + ((v1 * p5) <<< 17) + (p4 <<< 35);
        w1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
        r.press_invalid = (w1 == 0);
        r.press_pa_q8   = 32'd0;
        if (w1 != 0) begin
            pp  = 1048576 - rpl;
            num = ((pp <<< 31) - v2) * 3125;
            // The most negative dividend over minus one wraps back onto itself.
            if (num == longint'(64'h8000_0000_0000_0000) && w1 == -1) begin
                pp = num;
            end else begin
                pp = num / w1;
            end
            ps = pp >>> 13;
            e1 = (p9 * ps * ps) >>> 25;
            e2 = (p8 * pp) >>> 19;
            pp = ((pp + e1 + e2) >>> 8) + (p7 <<< 4);
            r.press_pa_q8 = pp[31:0];
        end

        // Humidity runs on 32 bits taken from the low half of the fine temperature.
        h1 = int'({24'd0, hum_cal_lo[7:0]});
        h2 = int'($signed(hum_cal_lo[23:8]));
        h3 = int'({24'd0, hum_cal_lo[31:24]});
        h4 = int'($signed(hum_cal_hi[11:0]));
        h5 = int'($signed(hum_cal_hi[23:12]));
        h6 = int'($signed(hum_cal_hi[31:24]));
        hv = int'(fine[31:0]) - 76800;
        x  = ((int'({16'd0, rh}) <<< 14) - (h4 <<< 20) - h5 * hv + 16384) >>> 15;
        i1 = (hv * h6) >>> 10;
        i2 = ((hv * h3) >>> 11) + 32768;
        tt = ((i1 * i2) >>> 10) + 2097152;
        tt = (tt * h2 + 8192) >>> 14;
        hval = x * tt;
        hs   = hval >>> 15;
        corr = (((hs * hs) >>> 7) * h1) >>> 4;
        hval = hval - corr;
        if (hval < 0) begin
            hval = 0;
        end else if (hval > 419430400) begin
            hval = 419430400;
        end
        hum_shifted = hval >>> 12;
        r.hum_q10   = hum_shifted[16:0];
        return r;
    endfunction

    // Writes one register; the caller lowers the write enable after the batch.
    task automatic write_reg(logic [escu_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            escu_pkg::CFG_TEMP_COEFFS:       temp_cal       = data[47:0];
            escu_pkg::CFG_PRESS_COEFFS_LOW:  press_cal_lo   = data;
            escu_pkg::CFG_PRESS_COEFFS_HIGH: press_cal_hi   = data;
            escu_pkg::CFG_PRESS_COEFF_NINE:  press_cal_nine = data[15:0];
            escu_pkg::CFG_HUM_COEFFS_LOW:    hum_cal_lo     = data[31:0];
            escu_pkg::CFG_HUM_COEFFS_HIGH:   hum_cal_hi     = data[31:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_calibration(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
                                    logic [63:0] p9, logic [63:0] hl, logic [63:0] hh);
        write_reg(escu_pkg::CFG_TEMP_COEFFS, tc);
        write_reg(escu_pkg::CFG_PRESS_COEFFS_LOW, pl);
        write_reg(escu_pkg::CFG_PRESS_COEFFS_HIGH, ph);
        write_reg(escu_pkg::CFG_PRESS_COEFF_NINE, p9);
        write_reg(escu_pkg::CFG_HUM_COEFFS_LOW, hl);
        write_reg(escu_pkg::CFG_HUM_COEFFS_HIGH, hh);
        // An unmapped index must leave every register untouched.
        write_reg(CFG_UNMAPPED, {$urandom, $urandom});
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one sample and returns at the edge where it transfers. Valid stays
    // high into the next sample unless a gap is drawn.
    task automatic offer_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh,
                                logic typed, t_reading typed_value);
        int gap;
        gap = 0;
        if (!steady_flow) begin
            case ($urandom_range(0, 19))
                0, 1, 2: gap = $urandom_range(1, 3);
                3:       gap = $urandom_range(10, 30);
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row_is_typed.push_back(typed);
        row_typed_value.push_back(typed_value);
        sample_if.valid     <= 1'b1;
        sample_if.raw_temp  <= rt;
        sample_if.raw_press <= rp;
        sample_if.raw_hum   <= rh;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
    endtask

    // Lets every outstanding reading arrive, then the pipeline settle.
    task automatic drain_pipeline();
        sample_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic random_samples(int count);
        logic [19:0] rt, rp;
        logic [15:0] rh;
        for (int n = 0; n < count; n++) begin
            // Mostly plausible readings, the rest anywhere in the field range.
            if ($urandom_range(0, 9) < 7) begin
                rt = 20'($urandom_range(380000, 650000));
                rp = 20'($urandom_range(200000, 500000));
                rh = 16'($urandom_range(15000, 45000));
            end else begin
                rt = 20'($urandom);
                rp = 20'($urandom);
                rh = 16'($urandom);
            end
            offer_sample(rt, rp, rh, 1'b0, ZERO_CAL_READING);
        end
    endtask

    task automatic report(string field, longint unsigned exp_v, longint unsigned act_v);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    endtask

    // Records each accepted sample and checks each accepted reading in order.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n) begin
            if (sample_if.valid && sample_if.ready) begin
                samples_taken++;
                if (row_is_typed.size() != 0 && row_is_typed.pop_front()) begin
                    pending_readings.push_back(row_typed_value.pop_front());
                end else begin
                    if (row_typed_value.size() != 0) void'(row_typed_value.pop_front());
                    pending_readings.push_back(compensate(sample_if.raw_temp,
                                                          sample_if.raw_press,
                                                          sample_if.raw_hum));
                end
            end
            if (result_if.valid && result_if.ready) begin
                if (pending_readings.size() == 0) begin
                    mismatches++;
                    $display("%0t: reading transferred with none outstanding", $time);
                end else begin
                    want = pending_readings.pop_front();
                    if (result_if.temp_centi !== want.temp_centi)
                        report("temp_centi", want.temp_centi, result_if.temp_centi);
                    if (result_if.press_pa_q8 !== want.press_pa_q8)
                        report("press_pa_q8", want.press_pa_q8, result_if.press_pa_q8);
                    if (result_if.hum_q10 !== want.hum_q10)
                        report("hum_q10", want.hum_q10, result_if.hum_q10);
                    if (result_if.press_invalid !== want.press_invalid)
                        report("press_invalid", want.press_invalid, result_if.press_invalid);
                    if (result_if.temp_out_of_range !== want.temp_out_of_range)
                        report("temp_out_of_range", want.temp_out_of_range,
                               result_if.temp_out_of_range);
                end
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off once traffic is
    // flowing so the pipeline fills up and pushes back on the sample channel.
    initial begin
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (!hold_done && samples_taken >= 80) begin
                hold_done = 1'b1;
                hold_left = 200;
                result_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 9) == 0) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
                end
            end
        end
    end

    initial begin
        sample_rows[0]  = '{20'd0,       20'd0,       16'd0,      ZERO_CAL_READING};
        sample_rows[1]  = '{20'hFFFFF,   20'hFFFFF,   16'hFFFF,   ZERO_CAL_READING};
        sample_rows[2]  = '{20'hFFFFF,   20'd0,       16'd0,      ZERO_CAL_READING};
        sample_rows[3]  = '{20'd0,       20'hFFFFF,   16'd0,      ZERO_CAL_READING};
        sample_rows[4]  = '{20'd0,       20'd0,       16'hFFFF,   ZERO_CAL_READING};
        sample_rows[5]  = '{20'h80000,   20'h80000,   16'h8000,   ZERO_CAL_READING};
        sample_rows[6]  = '{20'd519888,  20'd415148,  16'd28000,  ZERO_CAL_READING};
        sample_rows[7]  = '{20'h55555,   20'hAAAAA,   16'h5555,   ZERO_CAL_READING};
        sample_rows[8]  = '{20'hAAAAA,   20'h55555,   16'hAAAA,   ZERO_CAL_READING};
        sample_rows[9]  = '{20'd300000,  20'd150000,  16'd60000,  ZERO_CAL_READING};
        sample_rows[10] = '{20'd700000,  20'd550000,  16'd5000,   ZERO_CAL_READING};
        sample_rows[11] = '{20'd1,       20'd1,       16'd1,      ZERO_CAL_READING};

        mismatches     = 0;
        samples_taken  = 0;
        steady_flow    = 1'b0;
        temp_cal       = '0;
        press_cal_lo   = '0;
        press_cal_hi   = '0;
        press_cal_nine = '0;
        hum_cal_lo     = '0;
        hum_cal_hi     = '0;
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        sample_if.valid     <= 1'b0;
        sample_if.raw_temp  <= '0;
        sample_if.raw_press <= '0;
        sample_if.raw_hum   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: the expected readings come straight from the table.
        foreach (sample_rows[k])
            offer_sample(sample_rows[k].raw_temp, sample_rows[k].raw_press,
                         sample_rows[k].raw_hum, 1'b1, sample_rows[k].at_reset);
        drain_pipeline();

        // Nominal calibration: the same rows, then random traffic, all predicted.
        load_calibration(CAL_TEMP, CAL_P_LOW, CAL_P_HIGH, CAL_P_NINE, CAL_H_LOW, CAL_H_HIGH);
        foreach (sample_rows[k])
            offer_sample(sample_rows[k].raw_temp, sample_rows[k].raw_press,
                         sample_rows[k].raw_hum, 1'b0, ZERO_CAL_READING);
        random_samples(250);
        drain_pipeline();

        // Extremes: all ones, then 7FFF and 8000 per temperature or pressure field, 7F and 80 per humidity byte.
        load_calibration('1, '1, '1, '1, '1, '1);
        random_samples(100);
        drain_pipeline();
        steady_flow = 1'b1;
        load_calibration({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 64'h7FFF,
                         {8{8'h7F}}, {8{8'h7F}});
        random_samples(100);
        drain_pipeline();
        steady_flow = 1'b0;
        load_calibration({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 64'h8000,
                         {8{8'h80}}, {8{8'h80}});
        random_samples(100);
        drain_pipeline();

        // Random calibrations, alternating between near-nominal and arbitrary.
        for (int ph = 0; ph < 10; ph++) begin
            steady_flow = (ph % 4 == 3);
            if (ph % 2 == 0) begin
                load_calibration(CAL_TEMP ^ 64'($urandom_range(0, 255)),
                                 CAL_P_LOW ^ 64'($urandom_range(0, 255)),
                                 CAL_P_HIGH ^ 64'($urandom_range(0, 255)),
                                 CAL_P_NINE ^ 64'($urandom_range(0, 255)),
                                 CAL_H_LOW ^ 64'($urandom_range(0, 255)),
                                 CAL_H_HIGH ^ 64'($urandom_range(0, 255)));
            end else begin
                load_calibration({$urandom, $urandom}, {$urandom, $urandom},
                                 {$urandom, $urandom}, {$urandom, $urandom},
                                 {$urandom, $urandom}, {$urandom, $urandom});
            end
            random_samples(125);
            drain_pipeline();
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ env_sensor_compensation_unit.f @@
hdl/escu_pkg.sv
hdl/escu_if.sv
hdl/escu_div.sv
hdl/env_sensor_compensation_unit.sv
dv/env_sensor_compensation_unit_tb.sv
